FILE: rtl/core/dwm_pkg.sv
package dwm_pkg;

	localparam int MEM_WORDS = 1024;
	localparam int NUM_REGS  = 5;
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int REG_W     = $clog2(NUM_REGS);
	localparam int WORD_W    = 32;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// w / 1000 for w below 110000: (w * 134218) >> 27
	localparam logic [17:0] RECIP_1000 = 18'd134218;
	localparam int          SHIFT_1000 = 27;
	// q / 10 for q below 110: (q * 205) >> 11
	localparam logic [7:0]  RECIP_10   = 8'd205;
	localparam int          SHIFT_10   = 11;
	localparam logic [16:0] WORD_LIMIT = 17'd110000;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_EXEC    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DIVZERO = 2'd1,
		STS_BADREG  = 2'd2,
		STS_HALTED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMP_EQ = 2'd0,
		CMP_LT = 2'd1,
		CMP_GT = 2'd2
	} cmp_t;

	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_LOAD  = 4'd4;
	localparam logic [3:0] OP_STORE = 4'd5;
	localparam logic [3:0] OP_CMP   = 4'd6;
	localparam logic [3:0] OP_BR    = 4'd7;
	localparam logic [3:0] OP_DIV   = 4'd8;
	localparam logic [3:0] OP_READ  = 4'd9;
	localparam logic [3:0] OP_PRINT = 4'd10;

	localparam logic [3:0] BR_LT     = 4'd1;
	localparam logic [3:0] BR_LE     = 4'd2;
	localparam logic [3:0] BR_EQ     = 4'd3;
	localparam logic [3:0] BR_GT     = 4'd4;
	localparam logic [3:0] BR_GE     = 4'd5;
	localparam logic [3:0] BR_ALWAYS = 4'd6;

	localparam logic [0:0] CFG_START = 1'd0;
	localparam logic [0:0] CFG_END   = 1'd1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_FETCH,
		ST_DECODE,
		ST_OPER,
		ST_EXEC,
		ST_DIV,
		ST_DIVEND,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/dwm_ram.sv
module dwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/decimal_word_machine_execute.sv
// decimal word machine: one request per action (write word, read word, restart,
// execute one instruction) and exactly one result request per action. after reset
// the word memory is swept to zero, one word a cycle, across all MEM_WORDS (1024)
// words, during which no action is taken; configuration writes are always taken.
// an instruction passes fetch, two decode steps, operand read and execute, and a
// divide adds the one-bit-per-cycle restoring divider after execute. the single
// memory port pair sets the fetch and operand steps. a result waits in its own
// register, so the next action is taken while it is still stalled.
module decimal_word_machine_execute (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            action,
	input  logic [9:0]            address,
	input  logic signed [31:0]    value,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [31:0]    out_value,
	output logic                  out_valid,
	output logic                  halted,
	output logic [1:0]            status,
	output logic [9:0]            next_address,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [9:0]            cfg_data
);
	import dwm_pkg::*;

	localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_WORDS);

	state_t state_q, state_d;

	// configuration
	logic [9:0] prog_start_q, prog_end_q;

	// machine state
	logic [9:0]        pc_q;
	cmp_t              cmp_q;
	logic [WORD_W-1:0] rf_q [NUM_REGS];

	// per-request working registers
	logic [ADDR_W:0]   clr_q;
	logic [WORD_W-1:0] value_q;
	logic              rd_ok_q;
	logic              fetch_ok_q;
	logic [WORD_W-1:0] word_q;
	logic [6:0]        quot_q;
	logic [9:0]        opaddr_q;
	logic [3:0]        opc_q, rc_q;
	logic              nop_q;
	logic [REG_W-1:0]  dreg_q;
	logic [WORD_W-1:0] divisor_q, rem_q, quo_q;
	logic              dneg_q;
	logic [CNT_W-1:0]  dcnt_q;

	// pending result fields
	logic [WORD_W-1:0] pv_value_q;
	logic              pv_ovalid_q;
	status_t           pv_status_q;

	// memory
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	dwm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic accept, res_free, addr_ok, pc_ok, halted_now;
	assign accept     = item_valid && !item_stall;
	assign res_free   = !result_valid || !result_stall;
	assign addr_ok    = {1'b0, address} < MEM_LIMIT;
	assign pc_ok      = {1'b0, pc_q} < MEM_LIMIT;
	assign halted_now = pc_q > prog_end_q;
	assign cfg_ready  = 1'b1;

	// decode arithmetic
	logic [WORD_W-1:0] fword;
	logic [34:0]       q_prod;
	logic [16:0]       q_times_k;
	logic [16:0]       addr_full;
	logic [14:0]       opc_prod;
	logic [3:0]        opc_d;
	logic [7:0]        opc_x10;
	logic [3:0]        rc_d;
	logic              big_d;

	assign fword     = fetch_ok_q ? ram_rdata : '0;
	assign q_prod    = 35'(fword[16:0]) * 35'(RECIP_1000);
	assign q_times_k = 17'(quot_q) * 17'd1000;
	assign addr_full = word_q[16:0] - q_times_k;
	assign opc_prod  = 15'(quot_q) * 15'(RECIP_10);
	assign opc_d     = opc_prod[14:SHIFT_10];
	assign opc_x10   = 8'(opc_d) * 8'd10;
	assign rc_d      = 4'(8'(quot_q) - opc_x10);
	assign big_d     = (word_q[30:17] != '0) || (word_q[16:0] >= WORD_LIMIT);

	// execute step
	logic              uses_reg, reg_bad, take;
	logic              br_bad;
	logic [REG_W-1:0]  rsel;
	logic [WORD_W-1:0] rval, mval;
	logic [WORD_W-1:0] prod;

	assign uses_reg = (opc_q >= OP_ADD && opc_q <= OP_CMP) || opc_q == OP_DIV;
	assign reg_bad  = uses_reg && (32'(rc_q) >= NUM_REGS);
	assign rsel     = rc_q[REG_W-1:0];
	assign rval     = reg_bad ? '0 : rf_q[rsel];
	assign mval     = ram_rdata;
	assign prod     = rval * mval;

	always_comb begin
		take   = 1'b0;
		br_bad = 1'b0;
		case (rc_q)
			BR_LT:     take = cmp_q == CMP_LT;
			BR_LE:     take = cmp_q != CMP_GT;
			BR_EQ:     take = cmp_q == CMP_EQ;
			BR_GT:     take = cmp_q == CMP_GT;
			BR_GE:     take = cmp_q != CMP_LT;
			BR_ALWAYS: take = 1'b1;
			default:   br_bad = 1'b1;
		endcase
	end

	// divider step: shift one dividend bit into the remainder
	logic [32:0] div_shift, div_diff;
	assign div_shift = {rem_q, quo_q[WORD_W-1]};
	assign div_diff  = div_shift - {1'b0, divisor_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == MEM_LIMIT - 1'b1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_READ: state_d = ST_RDWAIT;
						ACT_EXEC: state_d = halted_now ? ST_DONE : ST_FETCH;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_DONE;
			ST_FETCH:  state_d = ST_DECODE;
			ST_DECODE: state_d = ST_OPER;
			ST_OPER:   state_d = ST_EXEC;
			ST_EXEC: begin
				if (!nop_q && !reg_bad && opc_q == OP_DIV && mval != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV:    if (dcnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DIVEND;
			ST_DIVEND: state_d = ST_DONE;
			ST_DONE:   if (res_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_stall = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = opaddr_q[ADDR_W-1:0];
		ram_wdata  = rval;
		ram_raddr  = opaddr_q[ADDR_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[ADDR_W-1:0];
				ram_wdata = '0;
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				ram_waddr  = address[ADDR_W-1:0];
				ram_wdata  = value;
				ram_raddr  = address[ADDR_W-1:0];
				if (item_valid) begin
					if (action_t'(action) == ACT_WRITE) ram_we = addr_ok;
					if (action_t'(action) == ACT_EXEC) ram_raddr = pc_q[ADDR_W-1:0];
				end
			end
			ST_EXEC: begin
				if (!nop_q && !reg_bad) begin
					if (opc_q == OP_STORE) ram_we = 1'b1;
					if (opc_q == OP_READ) begin
						ram_we    = 1'b1;
						ram_wdata = value_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_start_q <= '0;
			prog_end_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START: prog_start_q <= cfg_data;
				CFG_END:   prog_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// machine state and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			pc_q         <= '0;
			cmp_q        <= CMP_EQ;
			result_valid <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			// a new result replaces the one taken at this edge
			if (state_q == ST_DONE && res_free) result_valid <= 1'b1;
			else if (result_valid && !result_stall) result_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept && action_t'(action) == ACT_RESTART) begin
						pc_q  <= prog_start_q;
						cmp_q <= CMP_EQ;
					end
				end
				ST_EXEC: begin
					// a taken branch jumps, everything else advances
					pc_q <= (!nop_q && opc_q == OP_BR && take) ? opaddr_q : pc_q + 1'b1;
					if (!nop_q && !reg_bad) begin
						case (opc_q)
							OP_ADD:  rf_q[rsel] <= rval + mval;
							OP_SUB:  rf_q[rsel] <= rval - mval;
							OP_MUL:  rf_q[rsel] <= prod;
							OP_LOAD: rf_q[rsel] <= mval;
							OP_CMP: begin
								if (rval == mval) cmp_q <= CMP_EQ;
								else if ($signed(rval) < $signed(mval)) cmp_q <= CMP_LT;
								else cmp_q <= CMP_GT;
							end
							OP_BR: begin
								if (take) begin
									cmp_q <= CMP_EQ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIVEND: rf_q[dreg_q] <= dneg_q ? (~quo_q + 1'b1) : quo_q;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				value_q     <= value;
				rd_ok_q     <= addr_ok;
				fetch_ok_q  <= pc_ok;
				pv_value_q  <= '0;
				pv_ovalid_q <= 1'b0;
				pv_status_q <= (action_t'(action) == ACT_EXEC && halted_now) ?
				               STS_HALTED : STS_OK;
			end
			ST_RDWAIT: begin
				pv_value_q  <= rd_ok_q ? ram_rdata : '0;
				pv_ovalid_q <= rd_ok_q;
			end
			ST_FETCH: begin
				word_q <= fword;
				quot_q <= q_prod[SHIFT_1000+6:SHIFT_1000];
			end
			ST_DECODE: begin
				opaddr_q <= addr_full[9:0];
				opc_q    <= opc_d;
				rc_q     <= rc_d;
				nop_q    <= word_q[WORD_W-1] || big_d || opc_d == '0;
			end
			ST_EXEC: begin
				if (!nop_q) begin
					if (reg_bad) pv_status_q <= STS_BADREG;
					else if (opc_q == OP_BR && br_bad) pv_status_q <= STS_BADREG;
					else if (opc_q == OP_DIV && mval == '0) pv_status_q <= STS_DIVZERO;
					if (!reg_bad && opc_q == OP_PRINT) begin
						pv_value_q  <= mval;
						pv_ovalid_q <= 1'b1;
					end
				end
				// divider set-up on magnitudes
				dreg_q    <= rsel;
				dneg_q    <= rval[WORD_W-1] ^ mval[WORD_W-1];
				quo_q     <= rval[WORD_W-1] ? (~rval + 1'b1) : rval;
				divisor_q <= mval[WORD_W-1] ? (~mval + 1'b1) : mval;
				rem_q     <= '0;
				dcnt_q    <= '0;
			end
			ST_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (!div_diff[32]) begin
					rem_q <= div_diff[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (res_free) begin
					out_value    <= pv_value_q;
					out_valid    <= pv_ovalid_q;
					status       <= pv_status_q;
					halted       <= halted_now;
					next_address <= pc_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// the divider never runs with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> divisor_q != '0)
		else $error("divider running with zero divisor");

	// a halted step is only reported while halted
	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STS_HALTED |-> halted)
		else $error("halted status without halted flag");

	// nothing is taken while the memory sweep runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> item_stall)
		else $error("request taken during memory sweep");
`endif

endmodule
